>>> hw/rtl/iaid_pkg.sv
// Package: shared types, codes and constants for the indexed array insert/delete core.
`timescale 1ns / 1ps

package iaid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 2;
    localparam int POS_W        = 7;
    localparam int DATA_W       = 32;
    localparam int ST_W         = 2;
    localparam int COUNT_W      = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BOUNDS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_iaid_in;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] read_data;
        logic [COUNT_W-1:0]       count;
    } t_iaid_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_READ_WAIT,
        S_DONE
    } t_iaid_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_item;
        logic rd_shift;
        logic wr_shift;
        logic wr_value;
        logic fetch;
        logic finish;
    } t_iaid_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ok;
        logic is_ins;
        logic is_del;
        logic is_rd;
        logic more;
        logic out_free;
    } t_iaid_stat;

endpackage

>>> hw/rtl/iaid_ctrl.sv
// Controller: sequences decode, entry shifting, value write, read and result hand-off.
`timescale 1ns / 1ps

module iaid_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  iaid_pkg::t_iaid_stat i_stat,
    output iaid_pkg::t_iaid_cmd  o_cmd,
    output logic                 o_idle
);

    iaid_pkg::t_iaid_state r_state;
    iaid_pkg::t_iaid_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iaid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iaid_pkg::S_IDLE: begin
                if (i_start) n_state = iaid_pkg::S_DECODE;
            end
            iaid_pkg::S_DECODE: begin
                priority if (!i_stat.ok) n_state = iaid_pkg::S_DONE;
                else if (i_stat.is_rd)   n_state = iaid_pkg::S_READ_WAIT;
                else                     n_state = iaid_pkg::S_CHECK;
            end
            iaid_pkg::S_CHECK: begin
                priority if (i_stat.more) n_state = iaid_pkg::S_SHIFT_RD;
                else if (i_stat.is_ins)   n_state = iaid_pkg::S_WRITE;
                else                      n_state = iaid_pkg::S_DONE;
            end
            iaid_pkg::S_SHIFT_RD:  n_state = iaid_pkg::S_SHIFT_WR;
            iaid_pkg::S_SHIFT_WR:  n_state = iaid_pkg::S_CHECK;
            iaid_pkg::S_WRITE:     n_state = iaid_pkg::S_DONE;
            iaid_pkg::S_READ_WAIT: n_state = iaid_pkg::S_DONE;
            iaid_pkg::S_DONE: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) n_state = iaid_pkg::S_IDLE;
            end
            default: n_state = iaid_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_idle = 1'b0;
        unique case (r_state)
            iaid_pkg::S_IDLE: begin
                o_idle     = 1'b1;
                o_cmd.load = i_start;
            end
            iaid_pkg::S_DECODE:    o_cmd.rd_item  = i_stat.ok & i_stat.is_rd;
            iaid_pkg::S_CHECK:     o_cmd          = '0;
            iaid_pkg::S_SHIFT_RD:  o_cmd.rd_shift = 1'b1;
            iaid_pkg::S_SHIFT_WR:  o_cmd.wr_shift = 1'b1;
            iaid_pkg::S_WRITE:     o_cmd.wr_value = 1'b1;
            iaid_pkg::S_READ_WAIT: o_cmd.fetch    = 1'b1;
            iaid_pkg::S_DONE:      o_cmd.finish   = i_stat.out_free;
            default:               o_cmd          = '0;
        endcase
    end

endmodule

>>> hw/rtl/iaid_dpath.sv
// Datapath: entry memory, element count, working index, status and output register.
`timescale 1ns / 1ps

module iaid_dpath #(
    parameter int CAPACITY = iaid_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iaid_pkg::t_iaid_in   i_item,
    input  iaid_pkg::t_iaid_cmd  i_cmd,
    output iaid_pkg::t_iaid_stat o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output iaid_pkg::t_iaid_out  o_out_item
);

    localparam int UW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (UW > iaid_pkg::POS_W) ? UW : iaid_pkg::POS_W;

    logic signed [iaid_pkg::DATA_W-1:0] r_mem [CAPACITY];
    logic signed [iaid_pkg::DATA_W-1:0] r_rd_data;
    logic signed [iaid_pkg::DATA_W-1:0] r_val;
    logic signed [iaid_pkg::DATA_W-1:0] r_data;
    logic [iaid_pkg::OP_W-1:0]          r_op;
    logic [iaid_pkg::POS_W-1:0]         r_pos;
    logic [UW-1:0]                      r_used;
    logic [UW-1:0]                      n_used;
    logic [UW-1:0]                      r_idx;
    logic                               r_out_valid;
    iaid_pkg::t_iaid_out                r_out_item;

    logic [CMPW-1:0]            pos_ext;
    logic [CMPW-1:0]            in_pos_ext;
    logic [CMPW-1:0]            used_ext;
    logic [CMPW-1:0]            idx_ext;
    logic [CMPW-1:0]            n_used_ext;
    logic [UW:0]                idx_p1;
    logic [UW-1:0]              idx_m1;
    logic [iaid_pkg::ST_W-1:0]  status;
    logic                       is_ins;
    logic                       is_del;
    logic                       is_rd;
    logic                       ok;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [iaid_pkg::DATA_W-1:0] wr_data;

    assign pos_ext    = CMPW'(r_pos);
    assign in_pos_ext = CMPW'(i_item.position);
    assign used_ext   = CMPW'(r_used);
    assign idx_ext    = CMPW'(r_idx);
    assign idx_p1     = {1'b0, r_idx} + (UW+1)'(1);
    assign idx_m1     = r_idx - UW'(1);

    assign is_ins = (r_op == iaid_pkg::OP_INSERT);
    assign is_del = (r_op == iaid_pkg::OP_DELETE);
    assign is_rd  = (r_op == iaid_pkg::OP_READ);

    // Bounds check before the full check on insert
    always_comb begin
        status = iaid_pkg::ST_BOUNDS;
        priority if (is_ins) begin
            priority if (pos_ext > used_ext)         status = iaid_pkg::ST_BOUNDS;
            else if (r_used >= UW'(CAPACITY))       status = iaid_pkg::ST_FULL;
            else                                    status = iaid_pkg::ST_OK;
        end else if (is_del || is_rd) begin
            if (pos_ext < used_ext) status = iaid_pkg::ST_OK;
        end else begin
            status = iaid_pkg::ST_BOUNDS;
        end
    end

    assign ok = (status == iaid_pkg::ST_OK);

    assign o_stat.ok       = ok;
    assign o_stat.is_ins   = is_ins;
    assign o_stat.is_del   = is_del;
    assign o_stat.is_rd    = is_rd;
    assign o_stat.more     = is_ins ? (idx_ext > pos_ext) : (idx_p1 < {1'b0, r_used});
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Memory port steering: insert moves idx-1 to idx, delete moves idx+1 to idx
    always_comb begin
        rd_en = i_cmd.rd_item | i_cmd.rd_shift;
        priority if (i_cmd.rd_item) rd_addr = pos_ext[AW-1:0];
        else if (is_ins)            rd_addr = idx_m1[AW-1:0];
        else                        rd_addr = idx_p1[AW-1:0];
    end

    always_comb begin
        wr_en = i_cmd.wr_shift | i_cmd.wr_value;
        if (i_cmd.wr_value) begin
            wr_addr = pos_ext[AW-1:0];
            wr_data = r_val;
        end else begin
            wr_addr = r_idx[AW-1:0];
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_used = r_used;
        if (ok && is_ins) n_used = r_used + UW'(1);
        if (ok && is_del) n_used = r_used - UW'(1);
    end

    assign n_used_ext = CMPW'(n_used);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.op;
            r_pos <= i_item.position;
            r_val <= i_item.value;
            r_data <= '0;
            r_idx <= (i_item.op == iaid_pkg::OP_INSERT) ? r_used : in_pos_ext[UW-1:0];
        end else begin
            if (i_cmd.wr_shift) r_idx <= is_ins ? idx_m1 : idx_p1[UW-1:0];
            if (i_cmd.fetch)    r_data <= r_rd_data;
        end
        if (i_cmd.finish) begin
            r_out_item.status    <= status;
            r_out_item.read_data <= r_data;
            r_out_item.count     <= n_used_ext[iaid_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) r_used <= n_used;
            if (i_cmd.finish)     r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hw/rtl/indexed_array_insert_delete_core.sv
// From accept to result: a read passes decode, read wait and done; a failed item goes from
// decode to done; a delete runs check and move rounds, one per moved entry, and an insert
// also writes its value; the core then returns to idle. One item at a time; each moved entry
// costs a read, a write and a check on the one-read, one-write entry memory, which sets the rate.
// Synchronous active-low reset empties the list and clears the output valid flag;
// entry contents are not cleared.
`timescale 1ns / 1ps

module indexed_array_insert_delete_core #(
    parameter int CAPACITY = iaid_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iaid_pkg::t_iaid_in  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iaid_pkg::t_iaid_out o_out_item
);

    iaid_pkg::t_iaid_cmd  cmd;
    iaid_pkg::t_iaid_stat stat;
    logic                 idle;

    assign o_in_ready = idle;

    iaid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_in_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    iaid_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // One item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in flight");

    // Failed operations return zero data
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != iaid_pkg::ST_OK)) |-> (o_out_item.read_data == '0))
        else $error("nonzero read data on a failed operation");

    // A full report comes only with a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == iaid_pkg::ST_FULL))
            |-> (o_out_item.count == iaid_pkg::COUNT_W'(CAPACITY)))
        else $error("full status with list not at capacity");

endmodule
